// ===== design/swm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package swm_pkg;

  // Fixed field widths
  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned WIN_W    = 9;

  // Default depth of the cell row
  localparam int unsigned DEF_MAX_WINDOW = 256;

  // Window size after reset
  localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(1);

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // Control broadcast to every cell of the row
  typedef struct packed {
    logic load;   // a transaction was accepted this cycle
    logic first;  // that transaction starts a new sequence
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== design/swm_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

// One cell of the row: holds the maximum of the newest (index+1) samples.
module swm_cell import swm_pkg::*; (
  input  logic      clk_i,
  input  cell_ctl_t ctl_i,
  input  sample_t   sample_i,  // newest sample, broadcast
  input  sample_t   prev_i,    // running max held by the neighbor on the newer side
  output sample_t   next_o,    // value this cell takes at the coming edge
  output sample_t   max_o      // value held now, handed to the older neighbor
);

  sample_t max_q, max_d;

  // New running max; a new sequence restarts every cell at the sample
  always_comb begin
    if (ctl_i.first) begin
      max_d = sample_i;
    end else if (prev_i > sample_i) begin
      max_d = prev_i;
    end else begin
      max_d = sample_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      max_q <= max_d;
    end
  end

  assign next_o = max_d;
  assign max_o  = max_q;

endmodule

`default_nettype wire

// ===== design/swm_grp_sel.sv =====
`timescale 1ns / 1ps
`default_nettype none

// First level of the window tap: picks one cell of a group and registers it.
module swm_grp_sel import swm_pkg::*; #(
  parameter int unsigned LoBits = 4
) (
  input  logic              clk_i,
  input  logic              load_i,
  input  logic [LoBits-1:0] sel_i,
  input  sample_t           vals_i [1 << LoBits],
  output sample_t           grp_o
);

  sample_t grp_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      grp_q <= vals_i[sel_i];
    end
  end

  assign grp_o = grp_q;

endmodule

`default_nettype wire

// ===== design/sliding_window_max.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Sliding-window maximum. A row of MaxWindow cells keeps, in cell i, the maximum
// of the newest i+1 samples of the current sequence; every accepted transaction
// updates all cells at once, each comparing its newer neighbor's value with the
// new sample. The result of a transaction is the value of cell window_size-1,
// read through a two-level registered tap: the first level loads at the accepting
// edge, and the output register loads once the master side is free or takes its
// last result, which makes the result valid on the master side. The block takes
// one transaction per clock as long as the master side keeps up; a stalled
// result holds the pipeline. Nothing is emitted until window_size samples of the
// sequence have arrived. A window size of 0 acts as 1, and sizes above MaxWindow
// act as MaxWindow. There is no clearing pass after reset. Write the window size
// only while the block is idle.
module sliding_window_max import swm_pkg::*; #(
  parameter int unsigned MaxWindow = DEF_MAX_WINDOW
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Sample stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [SAMPLE_W-1:0] s_axis_tdata,   // [31:0] sample
  input  logic [0:0]          s_axis_tuser,   // [0] first_of_sequence
  // Window maximum stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [SAMPLE_W-1:0] m_axis_tdata,   // [31:0] window_max
  // Window size register
  input  logic                cfg_we_i,
  input  logic [WIN_W-1:0]    cfg_wdata_i
);

  localparam int unsigned SelW   = ($clog2(MaxWindow) < 2) ? 2 : $clog2(MaxWindow);
  localparam int unsigned LoBits = SelW / 2;
  localparam int unsigned HiBits = SelW - LoBits;
  localparam int unsigned NGrp   = 1 << HiBits;
  localparam int unsigned GrpSz  = 1 << LoBits;
  localparam int unsigned WinMax = (1 << WIN_W) - 1;
  localparam int unsigned WinCap = (MaxWindow > WinMax) ? WinMax : MaxWindow;
  localparam logic [WIN_W-1:0] WIN_CAP = WIN_W'(WinCap);

  logic [WIN_W-1:0]  win_q;
  logic [WIN_W-1:0]  w_eff;
  logic [WIN_W-1:0]  seen_q, seen_d, seen_base;
  logic              emit;
  logic [SelW-1:0]   sel_idx;
  logic [HiBits-1:0] hi_q;
  logic              v1_q;
  logic              out_valid_q;
  sample_t           out_q;
  logic              s_fire, adv2;
  cell_ctl_t         ctl;
  sample_t           sample;

  sample_t cell_next [MaxWindow];
  sample_t cell_max  [MaxWindow];
  sample_t grp_in    [NGrp][GrpSz];
  sample_t grp_val   [NGrp];

  // Handshake
  assign s_fire        = s_axis_tvalid & s_axis_tready;
  assign adv2          = v1_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~v1_q | adv2;
  assign sample        = s_axis_tdata;
  assign ctl.load      = s_fire;
  assign ctl.first     = s_axis_tuser[0];

  // Window size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= WIN_RESET;
    end else if (cfg_we_i) begin
      win_q <= cfg_wdata_i;
    end
  end

  // Effective window: zero acts as one, saturate at the row length
  always_comb begin
    if (win_q == '0) begin
      w_eff = WIN_W'(1);
    end else if (win_q > WIN_CAP) begin
      w_eff = WIN_CAP;
    end else begin
      w_eff = win_q;
    end
  end

  // Samples seen in this sequence, clamped to the window
  always_comb begin
    seen_base = ctl.first ? '0 : seen_q;
    if (seen_base > w_eff) begin
      seen_base = w_eff;
    end
    if (seen_base < w_eff) begin
      seen_d = seen_base + WIN_W'(1);
    end else begin
      seen_d = seen_base;
    end
    emit = (seen_d >= w_eff);
  end

  // Tap position of the window's oldest sample
  assign sel_idx = SelW'(32'(w_eff) - 32'd1);

  // Row of cells, newest at index 0
  for (genvar i = 0; i < MaxWindow; i++) begin : g_cell
    sample_t prev;
    if (i == 0) begin : g_head
      assign prev = sample;
    end else begin : g_body
      assign prev = cell_max[i-1];
    end
    swm_cell u_cell (
      .clk_i    (clk_i),
      .ctl_i    (ctl),
      .sample_i (sample),
      .prev_i   (prev),
      .next_o   (cell_next[i]),
      .max_o    (cell_max[i])
    );
  end

  // Group the cells for the first tap level; pad past the row end
  for (genvar g = 0; g < NGrp; g++) begin : g_grp
    for (genvar k = 0; k < GrpSz; k++) begin : g_ent
      if (g * GrpSz + k < MaxWindow) begin : g_real
        assign grp_in[g][k] = cell_next[g * GrpSz + k];
      end else begin : g_pad
        assign grp_in[g][k] = '0;
      end
    end
    swm_grp_sel #(
      .LoBits (LoBits)
    ) u_grp_sel (
      .clk_i  (clk_i),
      .load_i (s_fire),
      .sel_i  (sel_idx[LoBits-1:0]),
      .vals_i (grp_in[g]),
      .grp_o  (grp_val[g])
    );
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= '0;
      v1_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_fire) begin
        seen_q <= seen_d;
        v1_q   <= emit;
      end else if (adv2) begin
        v1_q <= 1'b0;
      end
      if (adv2) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Second tap level and output register
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      hi_q <= sel_idx[SelW-1:LoBits];
    end
    if (adv2) begin
      out_q <= grp_val[hi_q];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

`ifndef NO_ASSERTIONS
  // The sample count never passes the window in force at acceptance
  a_seen_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> (seen_q <= $past(w_eff)))
    else $error("sample count exceeds window");

  // A tap stage result exists exactly when the accepted sample filled the window
  a_emit_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> (v1_q == $past(emit)))
    else $error("tap stage valid does not follow emit");

  // A new sequence with a window above one produces nothing at once
  a_first_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && s_axis_tuser[0] && (w_eff != WIN_W'(1))) |=> !v1_q)
    else $error("result after first sample of a long window");

  // A tap result moving on always lands in the output register
  a_adv_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv2 |=> m_axis_tvalid)
    else $error("tap result lost");
`endif

endmodule

`default_nettype wire
